@@ rtl/core/touch_page_navigator_with_sleep_macros.svh @@
// Assertion helpers used by the navigator top level to check this block.
// Each helper samples on clk and is disabled while arst_n is low.
`ifndef TOUCH_PAGE_NAVIGATOR_WITH_SLEEP_MACROS_SVH
`define TOUCH_PAGE_NAVIGATOR_WITH_SLEEP_MACROS_SVH

// Check that a condition holds on every clock edge.
`define TPN_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("tpn check failed");

// Check that a condition on one edge implies another on the next edge.
`define TPN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpn sequence check failed");

`endif

@@ rtl/core/tpn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tpn_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned PageW = 3;

	// Page codes
	localparam logic [PageW-1:0] PAGE_DASHBOARD  = 3'd0;
	localparam logic [PageW-1:0] PAGE_DIAGNOSTIC = 3'd1;
	localparam logic [PageW-1:0] PAGE_NETWORK    = 3'd2;
	localparam logic [PageW-1:0] PAGE_GRAPH      = 3'd3;
	localparam logic [PageW-1:0] PAGE_DETAIL     = 3'd4;
	localparam logic [PageW-1:0] PAGE_ADAPTIVE   = 3'd5;

	// Configuration register indexes
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_HOLD_TIME     = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE      = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_SLEEP_TIMEOUT = 2'd2;

	// Register reset values
	localparam logic [TimeW-1:0] HOLD_TIME_RST     = 32'd10000;
	localparam logic [TimeW-1:0] DEBOUNCE_RST      = 32'd50;
	localparam logic [TimeW-1:0] SLEEP_TIMEOUT_RST = 32'd60000;

	typedef struct packed {
		logic [TimeW-1:0] hold_time_ms;
		logic [TimeW-1:0] debounce_ms;
		logic [TimeW-1:0] sleep_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic             prev_touch;
		logic             long_hold_done;
		logic [TimeW-1:0] press_start;
		logic [TimeW-1:0] last_activity;
		logic [TimeW-1:0] last_release;
		logic             sleeping;
		logic [PageW-1:0] page;
	} state_t;

	typedef struct packed {
		logic [PageW-1:0] page;
		logic             asleep;
		logic             detail_opened;
		logic             page_advanced;
		logic             went_to_sleep;
		logic             woke;
	} result_t;

	// Short-press page step: detail wraps to dashboard, others go (p + 1) mod 5
	function automatic logic [PageW-1:0] next_page(input logic [PageW-1:0] p);
		logic [PageW-1:0] n;
		unique case (p)
			PAGE_DASHBOARD:  n = PAGE_DIAGNOSTIC;
			PAGE_DIAGNOSTIC: n = PAGE_NETWORK;
			PAGE_NETWORK:    n = PAGE_GRAPH;
			PAGE_GRAPH:      n = PAGE_DETAIL;
			PAGE_DETAIL:     n = PAGE_DASHBOARD;
			PAGE_ADAPTIVE:   n = PAGE_DIAGNOSTIC;
			3'd6:            n = PAGE_NETWORK;
			default:         n = PAGE_GRAPH;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/tpn_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tpn_step (
	input  tpn_pkg::cfg_t              cfg,
	input  logic                       touch,
	input  logic [tpn_pkg::TimeW-1:0]  now,
	input  tpn_pkg::state_t            cur,
	output tpn_pkg::state_t            nxt,
	output tpn_pkg::result_t           res
);
	import tpn_pkg::*;

	logic             new_press;
	logic             lhd_base;
	logic [TimeW-1:0] press_base;
	logic [TimeW-1:0] hold_elapsed;
	logic [TimeW-1:0] rel_elapsed;
	logic [TimeW-1:0] idle_elapsed;
	logic             release_edge;
	logic             detail;
	logic             advance;
	logic             wake;
	logic             slept;
	logic             sleep_mid;
	logic [TimeW-1:0] act_mid;

	// Press start and hold timer
	assign new_press    = touch && !cur.prev_touch;
	assign press_base   = new_press ? now : cur.press_start;
	assign lhd_base     = new_press ? 1'b0 : cur.long_hold_done;
	assign hold_elapsed = now - press_base;
	assign detail       = touch && !cur.sleeping && !lhd_base
		&& (hold_elapsed >= cfg.hold_time_ms);

	// Release: wake first, else a debounced short press steps the page
	assign release_edge = !touch && cur.prev_touch;
	assign rel_elapsed  = now - cur.last_release;
	assign wake         = release_edge && cur.sleeping;
	assign advance      = release_edge && !cur.sleeping && !cur.long_hold_done
		&& (rel_elapsed >= cfg.debounce_ms);

	// Idle timeout measured from the activity time after this sample
	assign sleep_mid    = cur.sleeping && !wake;
	assign act_mid      = (touch || wake) ? now : cur.last_activity;
	assign idle_elapsed = now - act_mid;
	assign slept        = !sleep_mid && (idle_elapsed >= cfg.sleep_timeout_ms);

	always_comb begin
		nxt.prev_touch     = touch;
		nxt.long_hold_done = touch ? (lhd_base || detail) : cur.long_hold_done;
		nxt.press_start    = press_base;
		nxt.last_activity  = act_mid;
		nxt.last_release   = advance ? now : cur.last_release;
		nxt.sleeping       = sleep_mid || slept;
		priority if (detail) begin
			nxt.page = PAGE_DETAIL;
		end else if (advance) begin
			nxt.page = next_page(cur.page);
		end else begin
			nxt.page = cur.page;
		end

		res.page          = nxt.page;
		res.asleep        = nxt.sleeping;
		res.detail_opened = detail;
		res.page_advanced = advance;
		res.went_to_sleep = slept;
		res.woke          = wake;
	end

endmodule

`default_nettype wire

@@ rtl/core/touch_page_navigator_with_sleep.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "touch_page_navigator_with_sleep_macros.svh"

// Channel  Handshake               Payload
// in       in_valid / in_ready     touch_active, now_ms
// out      out_valid / out_ready   page, asleep, detail_opened, page_advanced,
//                                  went_to_sleep, woke
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One sample per cycle while results are taken: a beat lands in the input
// register, then one pass of subtract-and-compare logic updates the state and
// loads the result register.
// Reset clears the state and loads the register defaults; no clearing pass.
// A stalled result holds the sample stage; cfg_ready is always high.

module touch_page_navigator_with_sleep (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              touch_active,
	input  logic [tpn_pkg::TimeW-1:0]         now_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tpn_pkg::PageW-1:0]         page,
	output logic                              asleep,
	output logic                              detail_opened,
	output logic                              page_advanced,
	output logic                              went_to_sleep,
	output logic                              woke,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpn_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [tpn_pkg::TimeW-1:0]         cfg_data
);
	import tpn_pkg::*;

	cfg_t             cfg_q;
	state_t           state_q;
	state_t           state_nxt;
	result_t          res_nxt;
	result_t          res_q;
	logic             out_valid_q;
	logic             valid_s1;
	logic             touch_s1;
	logic [TimeW-1:0] now_s1;
	logic             step;

	assign cfg_ready = 1'b1;

	// Write configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_ms     <= HOLD_TIME_RST;
			cfg_q.debounce_ms      <= DEBOUNCE_RST;
			cfg_q.sleep_timeout_ms <= SLEEP_TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HOLD_TIME:     cfg_q.hold_time_ms     <= cfg_data;
				REG_DEBOUNCE:      cfg_q.debounce_ms      <= cfg_data;
				REG_SLEEP_TIMEOUT: cfg_q.sleep_timeout_ms <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Advance the sample stage when the result register is free
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture the sample beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			touch_s1 <= touch_active;
			now_s1   <= now_ms;
		end
	end

	tpn_step u_step (
		.cfg   (cfg_q),
		.touch (touch_s1),
		.now   (now_s1),
		.cur   (state_q),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// Commit the state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign page          = res_q.page;
	assign asleep        = res_q.asleep;
	assign detail_opened = res_q.detail_opened;
	assign page_advanced = res_q.page_advanced;
	assign went_to_sleep = res_q.went_to_sleep;
	assign woke          = res_q.woke;

	`TPN_ASSERT(a_page_range, state_q.page <= PAGE_ADAPTIVE)
	`TPN_ASSERT(a_detail_page, !(out_valid_q && res_q.detail_opened) || (res_q.page == PAGE_DETAIL))
	`TPN_ASSERT(a_one_event, !(out_valid_q && res_q.detail_opened && res_q.page_advanced))
	`TPN_ASSERT_NEXT(a_stall_holds, valid_s1 && out_valid_q && !out_ready, $stable(state_q) && valid_s1)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tpn_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 10;
	localparam int MAX_GAP = 6;
	localparam int LONG_STALL_AT = 80;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PAGE_COUNT = 5;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic             touch;
		logic [TimeW-1:0] ms;
	} sample_t;

	typedef struct {
		logic             prev_touch;
		logic             long_hold_done;
		logic [TimeW-1:0] press_start;
		logic [TimeW-1:0] last_activity;
		logic [TimeW-1:0] last_release;
		logic             sleeping;
		logic [PageW-1:0] page;
	} nav_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic touch_active = 1'b0;
	logic [TimeW-1:0] now_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PageW-1:0] page;
	logic asleep;
	logic detail_opened;
	logic page_advanced;
	logic went_to_sleep;
	logic woke;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [TimeW-1:0] cfg_data = '0;

	// Predictor copy of the registers and the navigator state
	logic [TimeW-1:0] cfg_hold;
	logic [TimeW-1:0] cfg_debounce;
	logic [TimeW-1:0] cfg_sleep;
	nav_state_t nav;

	sample_t sample_q[$];
	result_t expected_q[$];
	sample_t tx_item;
	result_t rx_want;
	logic [TimeW-1:0] wall_ms = '0;
	int n_sent = 0;
	int n_results = 0;
	int n_errors = 0;
	int tx_wait = 0;
	int tx_burst = 0;
	int rx_wait = 0;
	int rx_burst = 0;
	int idle_cycles = 0;

	touch_page_navigator_with_sleep DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.touch_active(touch_active),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.page(page),
		.asleep(asleep),
		.detail_opened(detail_opened),
		.page_advanced(page_advanced),
		.went_to_sleep(went_to_sleep),
		.woke(woke),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Pick the wait before the next beat; occasionally run a burst with no gaps
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Advance the navigator by one polled sample and return its result
	function automatic result_t navigate_sample(input logic touch, input logic [TimeW-1:0] now);
		result_t r;
		r = '0;
		if (touch) begin
			nav.last_activity = now;
			if (!nav.prev_touch) begin
				nav.press_start = now;
				nav.long_hold_done = 1'b0;
			end
			if (!nav.sleeping && !nav.long_hold_done &&
			    TimeW'(now - nav.press_start) >= cfg_hold) begin
				nav.page = PAGE_DETAIL;
				nav.long_hold_done = 1'b1;
				r.detail_opened = 1'b1;
			end
		end else if (nav.prev_touch) begin
			if (nav.sleeping) begin
				nav.sleeping = 1'b0;
				nav.last_activity = now;
				r.woke = 1'b1;
			end else if (!nav.long_hold_done &&
			             TimeW'(now - nav.last_release) >= cfg_debounce) begin
				nav.last_release = now;
				if (nav.page == PAGE_DETAIL)
					nav.page = PAGE_DASHBOARD;
				else
					nav.page = PageW'((int'(nav.page) + 1) % PAGE_COUNT);
				r.page_advanced = 1'b1;
			end
		end
		nav.prev_touch = touch;
		if (!nav.sleeping && TimeW'(now - nav.last_activity) >= cfg_sleep) begin
			nav.sleeping = 1'b1;
			r.went_to_sleep = 1'b1;
		end
		r.page = nav.page;
		r.asleep = nav.sleeping;
		return r;
	endfunction

	task automatic reset_navigator();
		cfg_hold = HOLD_TIME_RST;
		cfg_debounce = DEBOUNCE_RST;
		cfg_sleep = SLEEP_TIMEOUT_RST;
		nav.prev_touch = 1'b0;
		nav.long_hold_done = 1'b0;
		nav.press_start = '0;
		nav.last_activity = '0;
		nav.last_release = '0;
		nav.sleeping = 1'b0;
		nav.page = PAGE_DASHBOARD;
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			n_errors++;
		end
	endtask

	task automatic put(input logic touch, input logic [TimeW-1:0] ms);
		sample_t s;
		s.touch = touch;
		s.ms = ms;
		sample_q.push_back(s);
		n_sent++;
	endtask

	// Block until every queued sample has produced its result
	task automatic wait_drained();
		while (n_results != n_sent)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [TimeW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HOLD_TIME:     cfg_hold = val;
			REG_DEBOUNCE:      cfg_debounce = val;
			REG_SLEEP_TIMEOUT: cfg_sleep = val;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [TimeW-1:0] hold, input logic [TimeW-1:0] debounce,
	                         input logic [TimeW-1:0] sleep_ms);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_HOLD_TIME, hold);
		write_reg(REG_DEBOUNCE, debounce);
		write_reg(REG_SLEEP_TIMEOUT, sleep_ms);
	endtask

	// Press and release runs of random length on a rising clock, with some noise samples
	task automatic random_samples(input int n_items, input int unsigned step_max);
		int left;
		int run;
		logic level;
		left = n_items;
		level = 1'b0;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				wall_ms = $urandom();
				put($urandom_range(0, 1) != 0, wall_ms);
				left--;
			end else begin
				run = $urandom_range(1, 12);
				for (int k = 0; k < run && left > 0; k++) begin
					wall_ms += $urandom_range(0, step_max);
					put(level, wall_ms);
					left--;
				end
				level = ~level;
			end
		end
	endtask

	// Drive input beats from the pending queue, with random gaps between them
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_q.push_back(navigate_sample(tx_item.touch, tx_item.ms));
			if (!in_valid || in_ready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					tx_item = sample_q.pop_front();
					in_valid <= 1'b1;
					touch_active <= tx_item.touch;
					now_ms <= tx_item.ms;
					tx_wait = draw_gap(tx_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check result beats against the oldest prediction; stall ready at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, actual page %0d", $time, page);
					n_errors++;
				end else begin
					rx_want = expected_q.pop_front();
					check_field("page", rx_want.page, page);
					check_field("asleep", rx_want.asleep, asleep);
					check_field("detail_opened", rx_want.detail_opened, detail_opened);
					check_field("page_advanced", rx_want.page_advanced, page_advanced);
					check_field("went_to_sleep", rx_want.went_to_sleep, went_to_sleep);
					check_field("woke", rx_want.woke, woke);
					n_results++;
				end
				if (n_results == LONG_STALL_AT)
					rx_wait = LONG_STALL_CYCLES;
				else
					rx_wait = draw_gap(rx_burst);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Abort when no beat moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
			$display("touch_page_navigator_with_sleep verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_navigator();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: short press, debounce, long hold, sleep, hold while asleep, wrap
		put(1'b0, 32'd0);
		put(1'b1, 32'd100);
		put(1'b0, 32'd200);
		put(1'b1, 32'd210);
		put(1'b0, 32'd220);
		put(1'b1, 32'd300);
		put(1'b1, 32'd10300);
		put(1'b0, 32'd10400);
		put(1'b0, 32'd70300);
		put(1'b1, 32'd70400);
		put(1'b1, 32'd90000);
		put(1'b0, 32'd90010);
		put(1'b1, 32'hFFFF_FFF0);
		put(1'b0, 32'h0000_0010);
		put(1'b1, 32'hFFFF_FFFF);
		put(1'b0, 32'd0);

		// Zero hold and zero timeout: detail on the press sample, wake and sleep together
		configure('0, '0, '0);
		write_reg(REG_UNUSED, '1);
		put(1'b1, 32'd5);
		put(1'b0, 32'd6);

		// Longest hold and timeout: wake, then walk the pages with short presses
		configure('1, '0, '1);
		put(1'b1, 32'd7);
		put(1'b0, 32'd8);
		for (int k = 0; k < 5; k++) begin
			put(1'b1, 32'd20 + 2 * k);
			put(1'b0, 32'd21 + 2 * k);
		end

		// Random phases over several settings
		configure($urandom_range(0, 800), $urandom_range(0, 200), $urandom_range(1000, 4000));
		random_samples(200, 150);
		configure('0, '0, '0);
		random_samples(120, 100);
		configure('1, '1, '1);
		random_samples(120, 100);
		configure($urandom(), $urandom(), $urandom());
		random_samples(150, $urandom());
		configure($urandom_range(200, 2000), $urandom_range(0, 500), $urandom_range(300, 3000));
		random_samples(200, 300);
		configure(HOLD_TIME_RST, DEBOUNCE_RST, SLEEP_TIMEOUT_RST);
		random_samples(200, 1500);

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("touch_page_navigator_with_sleep verification clean");
		else
			$display("touch_page_navigator_with_sleep verification failed");
		$finish;
	end

endmodule
